[hdl/tlsc_pkg.sv]
// Shared types, constants and helper functions of the text line style checker.
// Used by tlsc_core, tlsc_out and text_line_style_checker; depends on nothing.
`default_nettype none

package tlsc_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int COUNT_BITS  = 32;

   localparam int LINE_LEN_W  = 16;
   localparam int NUM_W       = 32;
   localparam int MAX_LEN_W   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 120;

   localparam logic [CSR_INDEX_W-1:0] CSR_TAB_EN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIL_EN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_EN  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN  = 2'd3;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   localparam logic REPORT_LINE    = 1'b0;
   localparam logic REPORT_SUMMARY = 1'b1;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd240;

   typedef struct packed {
      logic                 tab_en;
      logic                 trail_en;
      logic                 long_en;
      logic [MAX_LEN_W-1:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic                  report_kind;
      logic [NUM_W-1:0]      line_number;
      logic                  tab_found;
      logic                  trailing_space_found;
      logic                  too_long;
      logic [LINE_LEN_W-1:0] line_length;
      logic                  nul_found;
      logic [NUM_W-1:0]      byte_total;
      logic [NUM_W-1:0]      line_total;
   } result_type;

   function automatic logic [NUM_W-1:0] clamp_num(input logic [63:0] value);
      logic [63:0] lim;
      lim = 64'(32'hFFFF_FFFF);
      return (value > lim) ? 32'hFFFF_FFFF : value[NUM_W-1:0];
   endfunction

   function automatic logic [LINE_LEN_W-1:0] clamp_len(input logic [63:0] value);
      logic [63:0] lim;
      lim = 64'(16'hFFFF);
      return (value > lim) ? 16'hFFFF : value[LINE_LEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/tlsc_core.sv]
// Input register, running line and file state, and result formation.
// Depends on tlsc_pkg.
`default_nettype none

module tlsc_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic                               req_tuser,   // kind
   input  wire logic [tlsc_pkg::REQ_DATA_W-1:0]    req_tdata,   // data_byte
   input  wire tlsc_pkg::cfg_type                  cfg,
   input  wire logic                               out_ready,
   output logic                                    res_valid,
   output tlsc_pkg::result_type                    res
);

   localparam logic [tlsc_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;
   localparam logic [tlsc_pkg::COUNT_BITS-1:0]  CNT_MAX = '1;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_kind_ff;
   logic [7:0] s1_byte_ff;
   logic       fire;

   logic [tlsc_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic                             cr_ff, cr_in;
   logic                             blank_ff, blank_in;
   logic                             tab_ff, tab_in;
   logic [tlsc_pkg::COUNT_BITS-1:0]  line_num_ff, line_num_in;
   logic [tlsc_pkg::COUNT_BITS-1:0]  bytes_ff, bytes_in;
   logic                             nul_ff, nul_in;
   logic                             full_ff, full_in;

   logic [tlsc_pkg::LENGTH_BITS-1:0] logical;
   logic [tlsc_pkg::COUNT_BITS-1:0]  lines;
   logic                             hit_tab, hit_trail, hit_long;
   logic                             is_eof, is_lf;

   assign fire        = s1_valid_ff && out_ready;
   assign req_tready  = !s1_valid_ff || out_ready;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff <= req_tuser;
         s1_byte_ff <= req_tdata[7:0];
      end
   end

   assign is_eof = (s1_kind_ff == tlsc_pkg::KIND_EOF);
   assign is_lf  = (s1_byte_ff == tlsc_pkg::CHAR_LF);

   always_comb begin
      logical = len_ff;
      if (cr_ff && (len_ff != '0) && (len_ff != LEN_MAX)) begin
         logical = len_ff - tlsc_pkg::LENGTH_BITS'(1);
      end
      hit_tab   = cfg.tab_en && tab_ff;
      hit_trail = cfg.trail_en && blank_ff;
      hit_long  = cfg.long_en && (64'(logical) > 64'(cfg.max_len));
      lines     = full_ff ? CNT_MAX : (line_num_ff - tlsc_pkg::COUNT_BITS'(1));
   end

   always_comb begin
      res = '0;
      res_valid = 1'b0;
      if (is_eof) begin
         res_valid       = fire;
         res.report_kind = tlsc_pkg::REPORT_SUMMARY;
         res.nul_found   = nul_ff;
         res.byte_total  = tlsc_pkg::clamp_num(64'(bytes_ff));
         res.line_total  = tlsc_pkg::clamp_num(64'(lines));
      end else begin
         res_valid                = fire && is_lf && (hit_tab || hit_trail || hit_long);
         res.report_kind          = tlsc_pkg::REPORT_LINE;
         res.line_number          = tlsc_pkg::clamp_num(64'(line_num_ff));
         res.tab_found            = hit_tab;
         res.trailing_space_found = hit_trail;
         res.too_long             = hit_long;
         res.line_length          = tlsc_pkg::clamp_len(64'(logical));
      end
   end

   always_comb begin
      len_in      = len_ff;
      cr_in       = cr_ff;
      blank_in    = blank_ff;
      tab_in      = tab_ff;
      line_num_in = line_num_ff;
      bytes_in    = bytes_ff;
      nul_in      = nul_ff;
      full_in     = full_ff;
      if (fire) begin
         if (is_eof) begin
            len_in      = '0;
            cr_in       = 1'b0;
            blank_in    = 1'b0;
            tab_in      = 1'b0;
            line_num_in = tlsc_pkg::COUNT_BITS'(1);
            bytes_in    = '0;
            nul_in      = 1'b0;
            full_in     = 1'b0;
         end else begin
            if (bytes_ff != CNT_MAX) begin
               bytes_in = bytes_ff + tlsc_pkg::COUNT_BITS'(1);
            end
            if (s1_byte_ff == tlsc_pkg::CHAR_NUL) begin
               nul_in = 1'b1;
            end
            if (is_lf) begin
               if (line_num_ff != CNT_MAX) begin
                  line_num_in = line_num_ff + tlsc_pkg::COUNT_BITS'(1);
               end else begin
                  full_in = 1'b1;
               end
               len_in   = '0;
               cr_in    = 1'b0;
               blank_in = 1'b0;
               tab_in   = 1'b0;
            end else begin
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + tlsc_pkg::LENGTH_BITS'(1);
               end
               if (s1_byte_ff == tlsc_pkg::CHAR_TAB) begin
                  tab_in = 1'b1;
               end
               if (s1_byte_ff == tlsc_pkg::CHAR_CR) begin
                  cr_in = 1'b1;
               end else begin
                  cr_in    = 1'b0;
                  blank_in = (s1_byte_ff == tlsc_pkg::CHAR_SPACE) ||
                             (s1_byte_ff == tlsc_pkg::CHAR_TAB);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         cr_ff       <= 1'b0;
         blank_ff    <= 1'b0;
         tab_ff      <= 1'b0;
         line_num_ff <= tlsc_pkg::COUNT_BITS'(1);
         bytes_ff    <= '0;
         nul_ff      <= 1'b0;
         full_ff     <= 1'b0;
      end else begin
         len_ff      <= len_in;
         cr_ff       <= cr_in;
         blank_ff    <= blank_in;
         tab_ff      <= tab_in;
         line_num_ff <= line_num_in;
         bytes_ff    <= bytes_in;
         nul_ff      <= nul_in;
         full_ff     <= full_in;
      end
   end

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && is_eof) |=> (line_num_ff == tlsc_pkg::COUNT_BITS'(1)) && (bytes_ff == '0)
         && !full_ff && !nul_ff && (len_ff == '0))
      else $error("file state not cleared after end of file");

   a_line_num_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_num_ff != '0)
      else $error("line number reached zero");

   a_lf_clears_line: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_eof && is_lf) |=> (len_ff == '0) && !tab_ff && !blank_ff && !cr_ff)
      else $error("line state not cleared after newline");

endmodule

`default_nettype wire

[hdl/tlsc_out.sv]
// Result register that holds one transaction for the rsp_ channel and packs it.
// Depends on tlsc_pkg.
`default_nettype none

module tlsc_out (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               res_valid,
   input  wire tlsc_pkg::result_type               res,
   output logic                                    out_ready,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tuser,  // report_kind
   // line_number, tab_found, trailing_space_found, too_long, line_length,
   // nul_found, byte_total, line_total, zero fill
   output logic [tlsc_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic                 valid_ff, valid_in;
   tlsc_pkg::result_type data_ff;

   assign out_ready = !valid_ff || rsp_tready;
   assign valid_in  = out_ready ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.report_kind;
   assign rsp_tdata  = {4'b0000,
                        data_ff.line_total,
                        data_ff.byte_total,
                        data_ff.nul_found,
                        data_ff.line_length,
                        data_ff.too_long,
                        data_ff.trailing_space_found,
                        data_ff.tab_found,
                        data_ff.line_number};

   a_line_has_hit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (data_ff.report_kind == tlsc_pkg::REPORT_LINE)) |->
         (data_ff.tab_found || data_ff.trailing_space_found || data_ff.too_long))
      else $error("line report without any finding");

   a_line_no_summary: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (data_ff.report_kind == tlsc_pkg::REPORT_LINE)) |->
         (!data_ff.nul_found && (data_ff.byte_total == '0) && (data_ff.line_total == '0)
          && (data_ff.line_number != '0)))
      else $error("line report carries summary fields");

   a_summary_no_line: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (data_ff.report_kind == tlsc_pkg::REPORT_SUMMARY)) |->
         ((data_ff.line_number == '0) && !data_ff.tab_found && (data_ff.line_length == '0)))
      else $error("summary carries line fields");

endmodule

`default_nettype wire

[hdl/text_line_style_checker.sv]
// Text line style checker: each req_ item passes the tlsc_core input register and the
// tlsc_out result register; one byte or EOF item per cycle unless rsp_tready stalls.
// Items that give no report produce no rsp_ transaction.
// Synchronous active-high reset clears line and file state, sets the line number to 1
// and loads the check enables to 1 and the maximum line length to 240.
// Depends on tlsc_pkg, tlsc_core and tlsc_out.
`default_nettype none

module text_line_style_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic                               req_tuser,   // kind
   input  wire logic [tlsc_pkg::REQ_DATA_W-1:0]    req_tdata,   // data_byte
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tuser,   // report_kind
   // line_number, tab_found, trailing_space_found, too_long, line_length,
   // nul_found, byte_total, line_total, zero fill
   output logic [tlsc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_write_enable,
   input  wire logic [tlsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tlsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   tlsc_pkg::cfg_type    cfg_ff, cfg_in;
   tlsc_pkg::result_type res;
   logic                 res_valid;
   logic                 out_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tlsc_pkg::CSR_TAB_EN:   cfg_in.tab_en   = csr_wdata[0];
            tlsc_pkg::CSR_TRAIL_EN: cfg_in.trail_en = csr_wdata[0];
            tlsc_pkg::CSR_LONG_EN:  cfg_in.long_en  = csr_wdata[0];
            tlsc_pkg::CSR_MAX_LEN:  cfg_in.max_len  = csr_wdata[tlsc_pkg::MAX_LEN_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tab_en   <= 1'b1;
         cfg_ff.trail_en <= 1'b1;
         cfg_ff.long_en  <= 1'b1;
         cfg_ff.max_len  <= tlsc_pkg::MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .out_ready  (out_ready),
      .res_valid  (res_valid),
      .res        (res)
   );

   tlsc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
